/* rtl/smdm_pkg.sv */
// shared types and constants for the signed multiply / divide / remainder unit
package smdm_pkg;

	localparam int WORD_W = 32;
	localparam int CNT_W  = $clog2(WORD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1,
		OP_REM = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIX,
		ST_DONE
	} state_t;

	// sequencer commands to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic fix;
	} ctrl_t;

endpackage

/* rtl/smdm_core.sv */
// datapath: operand registers and the one shared adder used for every step
module smdm_core
	import smdm_pkg::*;
(
	input  logic                     clk,
	input  ctrl_t                    ctrl,
	input  logic [1:0]               opcode,
	input  logic signed [WORD_W-1:0] operand_a,
	input  logic signed [WORD_W-1:0] operand_b,
	output logic signed [WORD_W-1:0] result
);

	op_t               op_q;
	logic [WORD_W-1:0] x_q;    // multiplicand (shifts left) or divisor
	logic [WORD_W-1:0] y_q;    // multiplier (shifts right) or dividend, then quotient
	logic [WORD_W-1:0] acc_q;  // product or partial remainder
	logic              neg_q;
	logic              rem_neg_q;
	logic              zero_q;
	logic [WORD_W-1:0] result_q;

	logic [WORD_W-1:0] mag_a;
	logic [WORD_W-1:0] mag_b;
	logic [WORD_W-1:0] add_a;
	logic [WORD_W-1:0] add_b;
	logic              add_cin;
	logic [WORD_W:0]   sum;
	logic [WORD_W-1:0] shifted;
	logic [WORD_W-1:0] fix_val;
	logic              fix_neg;

	assign mag_a   = operand_a[WORD_W-1] ? (~operand_a + 1'b1) : operand_a;
	assign mag_b   = operand_b[WORD_W-1] ? (~operand_b + 1'b1) : operand_b;
	assign shifted = {acc_q[WORD_W-2:0], y_q[WORD_W-1]};

	always_comb begin
		unique case (op_q)
			OP_DIV: begin
				fix_val = y_q;
				fix_neg = neg_q;
			end
			OP_REM: begin
				fix_val = acc_q;
				fix_neg = rem_neg_q;
			end
			default: begin
				fix_val = acc_q;
				fix_neg = neg_q;
			end
		endcase
	end

	// operand selection for the shared adder
	always_comb begin
		add_a   = acc_q;
		add_b   = x_q;
		add_cin = 1'b0;
		if (ctrl.fix) begin
			add_a   = fix_neg ? ~fix_val : fix_val;
			add_b   = '0;
			add_cin = fix_neg;
		end else if (op_q == OP_DIV || op_q == OP_REM) begin
			// trial subtract: carry out set means no borrow
			add_a   = shifted;
			add_b   = ~x_q;
			add_cin = 1'b1;
		end
	end

	assign sum = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_cin};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			op_q      <= op_t'(opcode);
			x_q       <= mag_b;
			y_q       <= mag_a;
			acc_q     <= '0;
			neg_q     <= operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
			rem_neg_q <= operand_a[WORD_W-1];
			zero_q    <= (op_t'(opcode) == OP_NOP) ||
				((op_t'(opcode) != OP_MUL) && (operand_b == '0));
		end else if (ctrl.step) begin
			if (op_q == OP_DIV || op_q == OP_REM) begin
				acc_q <= sum[WORD_W] ? sum[WORD_W-1:0] : shifted;
				y_q   <= {y_q[WORD_W-2:0], sum[WORD_W]};
			end else begin
				if (y_q[0]) begin
					acc_q <= sum[WORD_W-1:0];
				end
				x_q <= {x_q[WORD_W-2:0], 1'b0};
				y_q <= {1'b0, y_q[WORD_W-1:1]};
			end
		end else if (ctrl.fix) begin
			result_q <= zero_q ? '0 : sum[WORD_W-1:0];
		end
	end

	assign result = result_q;

endmodule

/* rtl/signed_mul_div_mod_unit.sv */
// after start is taken, the 32 bit steps run, then the sign fix, then the result beat
// no new start is taken while busy; a new start is taken in the strobe cycle
// the single 33-bit adder in the datapath does one multiply or divide bit per cycle
// the receiver cannot stall: result is valid only while done is high
// arst_n clears the sequencer to idle; operand and result registers are not reset
module signed_mul_div_mod_unit
	import smdm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               opcode,
	input  logic signed [WORD_W-1:0] operand_a,
	input  logic signed [WORD_W-1:0] operand_b,
	output logic                     done,
	output logic signed [WORD_W-1:0] result
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	ctrl_t            ctrl;

	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = accept ? ST_RUN : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = (state_q == ST_RUN) || (state_q == ST_FIX);
		done      = (state_q == ST_DONE);
		ctrl.load = start && !busy;
		ctrl.step = (state_q == ST_RUN);
		ctrl.fix  = (state_q == ST_FIX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	smdm_core u_core (
		.clk       (clk),
		.ctrl      (ctrl),
		.opcode    (opcode),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.result    (result)
	);

	a_done_after_fix: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_FIX)
		else $error("result beat without a sign fix cycle");

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RUN && cnt_q == '0)
		else $error("accepted beat did not start a clean run");

	a_fix_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIX |-> $past(cnt_q) == CNT_LAST)
		else $error("sign fix before all bit steps");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !ctrl.load)
		else $error("operands loaded while busy");

endmodule
